@@ hw/rtl/hsl_pkg.sv @@
package hsl_pkg;

  // Fixed-point widths: 1.0 is 2^16, so in-range operands need 17 bits
  localparam int unsigned FX_W  = 17;
  localparam int unsigned HUE_W = 16;
  localparam int unsigned SL_W  = 18;
  localparam int unsigned H6_W  = 19;
  // Chroma in 2^-32 units, at most 2^32
  localparam int unsigned C_W   = 33;
  // Channel terms in 2^-48 units, at most 2^48
  localparam int unsigned V_W   = 49;
  localparam int unsigned BYTE_W = 8;

  localparam logic [FX_W-1:0]   ONE_FX      = 17'h10000;
  localparam logic [BYTE_W-1:0] CHANNEL_MAX = 8'hFF;

  // Sixth of the hue circle
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYA = 3'd2,
    SEC_CYA_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

endpackage

@@ hw/rtl/hsl_scale255.sv @@
// Scale a channel term in 2^-48 units by 255 and keep the integer byte
module hsl_scale255 (
  input  logic [hsl_pkg::V_W-1:0]    value_i,
  output logic [hsl_pkg::BYTE_W-1:0] byte_o
);

  localparam int unsigned P_W = hsl_pkg::V_W + hsl_pkg::BYTE_W;

  logic [P_W-1:0] prod;

  // value * 255 as (value << 8) - value; value <= 2^48 keeps the result below 2^56
  assign prod = {value_i, 8'h00} - {8'h00, value_i};
  assign byte_o = prod[P_W-2 -: hsl_pkg::BYTE_W];

endmodule

@@ hw/rtl/hsl_to_rgb_converter_core.sv @@
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------------------------
// input    | in        | in_valid_i / in_ready_o   | hue_i, saturation_i, lightness_i
// output   | out       | out_valid_o / out_ready_i | red_o, green_o, blue_o, alpha_o, in_range_o
//
// Five register stages: range check and hue split, chroma multiply, x multiply and
// offset, channel select and add, scale by 255 into the output register.
// Accepts one transaction per cycle unless back-pressure from out_ready_i has filled every stage.
// Each stage holds its transaction while the stage after it is full and stalled,
// and bubbles are squeezed out, so in_ready_o is low only when all stages are full.
// Reset clears the valid bits only; payload registers are not reset.
module hsl_to_rgb_converter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hsl_pkg::HUE_W-1:0]        hue_i,
  input  logic signed [hsl_pkg::SL_W-1:0]  saturation_i,
  input  logic signed [hsl_pkg::SL_W-1:0]  lightness_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hsl_pkg::BYTE_W-1:0]       red_o,
  output logic [hsl_pkg::BYTE_W-1:0]       green_o,
  output logic [hsl_pkg::BYTE_W-1:0]       blue_o,
  output logic [hsl_pkg::BYTE_W-1:0]       alpha_o,
  output logic                             in_range_o
);

  localparam int unsigned FX_W = hsl_pkg::FX_W;
  localparam int unsigned C_W  = hsl_pkg::C_W;
  localparam int unsigned V_W  = hsl_pkg::V_W;
  localparam int unsigned B_W  = hsl_pkg::BYTE_W;

  // Valid bits and stage readiness
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---------------- Stage 1: range check, 1-|2l-1|, hue split ----------------
  logic [hsl_pkg::SL_W-1:0] sat_u, light_u, two_l, abs_a, oma_w;
  logic [hsl_pkg::H6_W-1:0] h6;
  logic [FX_W-1:0]          frac, abs_d, omd_w;

  logic                 ok1_d, ok1_q;
  logic [FX_W-1:0]      sat1_d, sat1_q, light1_d, light1_q, oma1_d, oma1_q, omd1_d, omd1_q;
  hsl_pkg::sector_e     sec1_d, sec1_q;

  always_comb begin
    sat_u   = $unsigned(saturation_i);
    light_u = $unsigned(lightness_i);
    ok1_d   = (sat_u <= {1'b0, hsl_pkg::ONE_FX}) && (light_u <= {1'b0, hsl_pkg::ONE_FX});
    two_l   = {light_u[FX_W-1:0], 1'b0};
    if (two_l >= {1'b0, hsl_pkg::ONE_FX}) begin
      abs_a = two_l - {1'b0, hsl_pkg::ONE_FX};
    end else begin
      abs_a = {1'b0, hsl_pkg::ONE_FX} - two_l;
    end
    oma_w    = {1'b0, hsl_pkg::ONE_FX} - abs_a;
    oma1_d   = oma_w[FX_W-1:0];
    h6       = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
    sec1_d   = hsl_pkg::sector_e'(h6[hsl_pkg::H6_W-1 -: 3]);
    frac     = h6[FX_W-1:0];
    if (frac >= hsl_pkg::ONE_FX) begin
      abs_d = frac - hsl_pkg::ONE_FX;
    end else begin
      abs_d = hsl_pkg::ONE_FX - frac;
    end
    omd_w    = hsl_pkg::ONE_FX - abs_d;
    omd1_d   = omd_w;
    sat1_d   = sat_u[FX_W-1:0];
    light1_d = light_u[FX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ok1_q    <= ok1_d;
      sat1_q   <= sat1_d;
      light1_q <= light1_d;
      oma1_q   <= oma1_d;
      omd1_q   <= omd1_d;
      sec1_q   <= sec1_d;
    end
  end

  // ---------------- Stage 2: chroma c = s * (1-|2l-1|) ----------------
  logic [2*FX_W-1:0] c_prod;
  logic [C_W-1:0]    c2_d, c2_q;
  logic              ok2_q;
  logic [FX_W-1:0]   light2_q, omd2_q;
  hsl_pkg::sector_e  sec2_q;

  assign c_prod = sat1_q * oma1_q;
  assign c2_d   = c_prod[C_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      c2_q     <= c2_d;
      ok2_q    <= ok1_q;
      light2_q <= light1_q;
      omd2_q   <= omd1_q;
      sec2_q   <= sec1_q;
    end
  end

  // ---------------- Stage 3: x = c * (1-|h6 mod 2 - 1|), m = l - c/2 ----------------
  logic [C_W+FX_W-1:0] x_prod;
  logic [V_W-1:0]      x3_d, x3_q, c3_d, c3_q, m3_d, m3_q;
  logic                ok3_q;
  hsl_pkg::sector_e    sec3_q;

  always_comb begin
    x_prod = c2_q * omd2_q;
    x3_d   = x_prod[V_W-1:0];
    c3_d   = {c2_q, 16'h0000};
    m3_d   = {light2_q, 32'h0000_0000} - {1'b0, c2_q, 15'h0000};
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      x3_q   <= x3_d;
      c3_q   <= c3_d;
      m3_q   <= m3_d;
      ok3_q  <= ok2_q;
      sec3_q <= sec2_q;
    end
  end

  // ---------------- Stage 4: pick c, x or 0 per channel, add m ----------------
  logic [V_W-1:0] r_sel, g_sel, b_sel;
  logic [V_W-1:0] r4_d, r4_q, g4_d, g4_q, b4_d, b4_q;
  logic           ok4_q;

  always_comb begin
    unique case (sec3_q)
      hsl_pkg::SEC_RED_YEL: begin
        r_sel = c3_q; g_sel = x3_q; b_sel = '0;
      end
      hsl_pkg::SEC_YEL_GRN: begin
        r_sel = x3_q; g_sel = c3_q; b_sel = '0;
      end
      hsl_pkg::SEC_GRN_CYA: begin
        r_sel = '0;   g_sel = c3_q; b_sel = x3_q;
      end
      hsl_pkg::SEC_CYA_BLU: begin
        r_sel = '0;   g_sel = x3_q; b_sel = c3_q;
      end
      hsl_pkg::SEC_BLU_MAG: begin
        r_sel = x3_q; g_sel = '0;   b_sel = c3_q;
      end
      default: begin
        r_sel = c3_q; g_sel = '0;   b_sel = x3_q;
      end
    endcase
    r4_d = r_sel + m3_q;
    g4_d = g_sel + m3_q;
    b4_d = b_sel + m3_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      r4_q  <= r4_d;
      g4_q  <= g4_d;
      b4_q  <= b4_d;
      ok4_q <= ok3_q;
    end
  end

  // ---------------- Stage 5: scale by 255, blank out-of-range transactions ----------------
  logic [B_W-1:0] r_byte, g_byte, b_byte;
  logic [B_W-1:0] red_d, red_q, green_d, green_q, blue_d, blue_q, alpha_d, alpha_q;
  logic           ok5_q;

  hsl_scale255 u_scale_r (.value_i(r4_q), .byte_o(r_byte));
  hsl_scale255 u_scale_g (.value_i(g4_q), .byte_o(g_byte));
  hsl_scale255 u_scale_b (.value_i(b4_q), .byte_o(b_byte));

  always_comb begin
    red_d   = ok4_q ? r_byte : '0;
    green_d = ok4_q ? g_byte : '0;
    blue_d  = ok4_q ? b_byte : '0;
    alpha_d = ok4_q ? hsl_pkg::CHANNEL_MAX : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
      ok5_q   <= ok4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign in_range_o  = ok5_q;

`ifndef SYNTHESIS
  // Out-of-range transactions come out blank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |->
      (red_o == '0) && (green_o == '0) && (blue_o == '0) && (alpha_o == '0))
    else $error("out-of-range transaction not blanked");

  // In-range transactions carry full alpha
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> alpha_o == hsl_pkg::CHANNEL_MAX)
    else $error("alpha wrong for in-range transaction");

  // Input stalls only when every stage is full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && v4_q && v5_q && !out_ready_i)
    else $error("input stalled with a free stage");

  // A blocked output transaction is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(in_range_o))
    else $error("stalled output transaction changed");
`endif

endmodule
